// ----- hdl/pwm_pkg.sv -----
// pwm_pkg: types, constants and key tables of the packet word scrambler
// no dependencies; imported by the interfaces and every module of the block
`timescale 1ns / 1ps

package pwm_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 3;
  localparam int KIND_W  = 3;
  localparam int INDEX_W = 4;
  localparam int LANES   = 4;
  localparam int BYTE_W  = 8;

  localparam logic [1:0] TABLE_NONE = 2'd3;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  // control shared by all byte lanes for one item
  typedef struct packed {
    logic [1:0] tsel;
    index_t     idx;
  } lane_ctrl_t;

  // fixed part of the key byte for lane j: 0xa5 | (j << j) | j
  function automatic byte_t lane_const(input int j);
    byte_t r;
    r = 8'hA5 | 8'((j << j) | j);
    return r;
  endfunction

  function automatic byte_t table_byte(input logic [1:0] tsel, input index_t pos);
    byte_t r;
    r = 8'h00;
    case (tsel)
      2'd0: begin
        case (pos)
          4'd0: r = 8'h7A;   4'd1: r = 8'h64;   4'd2: r = 8'h05;   4'd3: r = 8'hF1;
          4'd4: r = 8'h1B;   4'd5: r = 8'h9B;   4'd6: r = 8'hA0;   4'd7: r = 8'hB5;
          4'd8: r = 8'hCA;   4'd9: r = 8'hED;   4'd10: r = 8'h61;  4'd11: r = 8'h0D;
          4'd12: r = 8'h4A;  4'd13: r = 8'hDF;  4'd14: r = 8'h8E;  default: r = 8'hC7;
        endcase
      end
      2'd1: begin
        case (pos)
          4'd0: r = 8'h05;   4'd1: r = 8'h61;   4'd2: r = 8'h7A;   4'd3: r = 8'hED;
          4'd4: r = 8'h1B;   4'd5: r = 8'hCA;   4'd6: r = 8'h0D;   4'd7: r = 8'h9B;
          4'd8: r = 8'h4A;   4'd9: r = 8'hF1;   4'd10: r = 8'h64;  4'd11: r = 8'hC7;
          4'd12: r = 8'hB5;  4'd13: r = 8'h8E;  4'd14: r = 8'hDF;  default: r = 8'hA0;
        endcase
      end
      2'd2: begin
        case (pos)
          4'd0: r = 8'h20;   4'd1: r = 8'h07;   4'd2: r = 8'h13;   4'd3: r = 8'h61;
          4'd4: r = 8'h03;   4'd5: r = 8'h45;   4'd6: r = 8'h17;   4'd7: r = 8'h72;
          4'd8: r = 8'h0A;   4'd9: r = 8'h2D;   4'd10: r = 8'h48;  4'd11: r = 8'h0C;
          4'd12: r = 8'h4A;  4'd13: r = 8'h12;  4'd14: r = 8'hA9;  default: r = 8'hB5;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic word_t swap_bytes(input word_t w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ----- hdl/pwm_word_if.sv -----
// pwm_word_if: valid/ready channel carrying one packet word item
// depends on pwm_pkg
`timescale 1ns / 1ps

interface pwm_word_if;
  import pwm_pkg::*;

  logic   valid;
  logic   ready;
  word_t  data_word;
  count_t byte_count;
  word_t  seq_value;
  logic   first_word;
  kind_t  kind;

  modport source (output valid, data_word, byte_count, seq_value, first_word, kind,
                  input ready);
  modport sink   (input valid, data_word, byte_count, seq_value, first_word, kind,
                  output ready);
endinterface

// ----- hdl/pwm_result_if.sv -----
// pwm_result_if: valid/ready channel carrying one transformed word item
// depends on pwm_pkg
`timescale 1ns / 1ps

interface pwm_result_if;
  import pwm_pkg::*;

  logic   valid;
  logic   ready;
  word_t  result_word;
  count_t result_bytes;

  modport source (output valid, result_word, result_bytes, input ready);
  modport sink   (input valid, result_word, result_bytes, output ready);
endinterface

// ----- hdl/pwm_lane.sv -----
// pwm_lane: one byte lane, xors its byte with the lane key byte
// depends on pwm_pkg key tables
`timescale 1ns / 1ps

module pwm_lane #(
  parameter int LANE = 0
) (
  input  pwm_pkg::lane_ctrl_t ctrl,
  input  pwm_pkg::byte_t      data_byte,
  output pwm_pkg::byte_t      keyed_byte
);
  import pwm_pkg::*;

  localparam byte_t LANE_KEY = lane_const(LANE);

  index_t pos;
  byte_t  key;

  // table position wraps mod 16
  assign pos        = ctrl.idx + INDEX_W'(LANE);
  assign key        = LANE_KEY | table_byte(ctrl.tsel, pos);
  assign keyed_byte = data_byte ^ key;

endmodule

// ----- hdl/packet_word_munge.sv -----
// packet_word_munge: top level, word index, byte swaps, lane merge, output skid
// depends on pwm_pkg, pwm_word_if, pwm_result_if and pwm_lane
`timescale 1ns / 1ps
//
//  channel  | modport | payload
//  ---------+---------+-------------------------------------------------
//  words    | sink    | data_word, byte_count, seq_value, first_word, kind
//  results  | source  | result_word, result_bytes
//
//  one item per cycle while words.ready is high; a taken item is registered in the
//  output register, or in the skid entry when stalled; all four byte lanes and the
//  swap/merge logic feed both; this two-entry buffer keeps words.ready high while
//  one result waits; rst (synchronous) clears the word index and both entries
//  words.ready drops only when both output entries hold untaken results

module packet_word_munge (
  input logic          clk,
  input logic          rst,
  pwm_word_if.sink     words,
  pwm_result_if.source results
);
  import pwm_pkg::*;

  index_t     word_index;
  index_t     idx_use;
  logic       active;
  logic       reverse;
  logic       accept;
  lane_ctrl_t ctrl;
  word_t      pre;
  word_t      keyed;
  word_t      merged;
  word_t      next_word;

  logic   out_valid;
  word_t  out_word;
  count_t out_bytes;
  logic   skid_valid;
  word_t  skid_word;
  count_t skid_bytes;

  assign ctrl.tsel = words.kind[2:1];
  assign reverse   = words.kind[0];
  assign idx_use   = words.first_word ? '0 : word_index;
  assign ctrl.idx  = idx_use;
  // full word (count four or more) with a real table
  assign active    = words.byte_count[2] && (ctrl.tsel != TABLE_NONE);

  assign pre = reverse ? (words.data_word ^ words.seq_value)
                       : swap_bytes(words.data_word ^ words.seq_value);

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    pwm_lane #(.LANE(j)) u_lane (
      .ctrl       (ctrl),
      .data_byte  (pre[BYTE_W*j +: BYTE_W]),
      .keyed_byte (keyed[BYTE_W*j +: BYTE_W])
    );
  end

  assign merged    = (reverse ? swap_bytes(keyed) : keyed) ^ ~words.seq_value;
  assign next_word = active ? merged : words.data_word;

  assign words.ready = !skid_valid;
  assign accept      = words.valid && words.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
    end else if (accept) begin
      word_index <= active ? idx_use + 1'b1 : idx_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (results.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_word   <= skid_word;
        out_bytes  <= skid_bytes;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) begin
          out_word  <= next_word;
          out_bytes <= words.byte_count;
        end
      end
    end else if (accept) begin
      // output stalled: park the new item
      skid_valid <= 1'b1;
      skid_word  <= next_word;
      skid_bytes <= words.byte_count;
    end
  end

  assign results.valid        = out_valid;
  assign results.result_word  = out_word;
  assign results.result_bytes = out_bytes;

endmodule
